/* hw/rtl/spt_pkg.sv */
// Shared types, constants and arithmetic helpers for the scan point transform.
// Used by spt_front, spt_cell, spt_combine and scan_point_pan_tilt_transform.
package spt_pkg;

  localparam int MAX_SAMPLES    = 1024;
  localparam int ROTATION_STEPS = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_INC   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ANGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_ARM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_ARM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SHIFT  = 3'd5;

  localparam logic [9:0] IDX_MAX = 10'(MAX_SAMPLES - 1);

  // angles in 2^-24 rad
  localparam logic signed [27:0] PI_A      = 28'sd52707179;
  localparam logic signed [27:0] HALF_PI_A = 28'sd26353589;
  localparam logic signed [29:0] TWO_PI_1  = 30'sd105414357;
  localparam logic signed [29:0] TWO_PI_2  = 30'sd210828714;
  localparam logic signed [29:0] TWO_PI_3  = 30'sd316243071;
  localparam logic signed [29:0] TWO_PI_4  = 30'sd421657428;

  localparam logic signed [31:0] CORDIC_START = 32'sd652032874;

  localparam logic signed [57:0] OUT_MAX = 58'sd2097151;
  localparam logic signed [57:0] OUT_MIN = -58'sd2097152;

  typedef struct packed {
    logic [17:0]        angle_inc;
    logic signed [15:0] first_angle;
    logic [15:0]        tilt_arm;
    logic [15:0]        pan_arm;
    logic [15:0]        base_height;
    logic [15:0]        base_shift;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    angle_inc:   18'd102944,
    first_angle: -16'sd17154,
    tilt_arm:    16'd720,
    pan_arm:     16'd640,
    base_height: 16'd1824,
    base_shift:  16'd455
  };

  // one rotation lane: vector, residual angle, and the half-turn fold flag
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [27:0] z;
    logic               neg;
  } lane_t;

  typedef struct packed {
    lane_t       beam;
    lane_t       pan;
    lane_t       tilt;
    logic [19:0] range;
  } cell_data_t;

  // two partial products of a 38 x 18 bit multiplication
  typedef struct packed {
    logic signed [36:0] hi;
    logic signed [37:0] lo;
  } part_t;

  function automatic logic signed [27:0] atan_of(input logic [4:0] i);
    logic signed [27:0] r;
    case (i)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

  // bring an angle into [-pi, pi] by whole turns
  function automatic logic signed [27:0] wrap_angle(input logic signed [29:0] a);
    logic signed [29:0] r;
    r = a;
    if (a > PI_A) begin
      if (a - TWO_PI_1 <= PI_A) r = a - TWO_PI_1;
      else if (a - TWO_PI_2 <= PI_A) r = a - TWO_PI_2;
      else if (a - TWO_PI_3 <= PI_A) r = a - TWO_PI_3;
      else r = a - TWO_PI_4;
    end else if (a < -PI_A) begin
      r = a + TWO_PI_1;
    end
    return r[27:0];
  endfunction

  // fold into [-pi/2, pi/2] and load the rotation start vector
  function automatic lane_t fold_lane(input logic signed [27:0] a);
    lane_t l;
    l.x   = CORDIC_START;
    l.y   = '0;
    l.z   = a;
    l.neg = 1'b0;
    if (a > HALF_PI_A) begin
      l.z   = a - PI_A;
      l.neg = 1'b1;
    end else if (a < -HALF_PI_A) begin
      l.z   = a + PI_A;
      l.neg = 1'b1;
    end
    return l;
  endfunction

  // one rotation-mode step
  function automatic lane_t cordic_step(input lane_t l, input logic [4:0] sh,
                                        input logic signed [27:0] at);
    logic signed [31:0] xs, ys, dx, dy;
    logic signed [27:0] zs;
    lane_t o;
    xs = l.x;
    ys = l.y;
    zs = l.z;
    dx = ys >>> sh;
    dy = xs >>> sh;
    o  = l;
    if (zs >= 28'sd0) begin
      o.x = xs - dx;
      o.y = ys + dy;
      o.z = zs - at;
    end else begin
      o.x = xs + dx;
      o.y = ys - dy;
      o.z = zs + at;
    end
    return o;
  endfunction

  // round Q30 to Q16 and undo the fold
  function automatic logic signed [17:0] round_trig(input logic signed [31:0] v,
                                                    input logic neg);
    logic signed [31:0] t;
    t = (v + 32'sd8192) >>> 14;
    if (neg) t = -t;
    return t[17:0];
  endfunction

  function automatic part_t mul_split(input logic signed [37:0] a,
                                      input logic signed [17:0] b);
    logic signed [18:0] ah;
    logic signed [19:0] al;
    part_t p;
    ah   = a[37:19];
    al   = $signed({1'b0, a[18:0]});
    p.hi = ah * b;
    p.lo = al * b;
    return p;
  endfunction

  function automatic logic signed [55:0] mul_join(input part_t p);
    logic signed [36:0] hs;
    logic signed [37:0] ls;
    logic signed [55:0] h, l;
    hs = p.hi;
    ls = p.lo;
    h  = hs;
    l  = ls;
    return (h <<< 19) + l;
  endfunction

  // round the Q32 sum to whole units and clamp to 22 bits
  function automatic logic signed [21:0] sat_out(input logic signed [57:0] acc);
    logic signed [57:0] v;
    logic signed [21:0] r;
    v = (acc + (58'sd1 <<< 31)) >>> 32;
    if (v > OUT_MAX) r = OUT_MAX[21:0];
    else if (v < OUT_MIN) r = OUT_MIN[21:0];
    else r = v[21:0];
    return r;
  endfunction

endpackage

/* hw/rtl/spt_front.sv */
// Angle front end: beam angle, turn wrap and quadrant fold for three lanes.
// Depends on spt_pkg; feeds the first spt_cell.
module spt_front import spt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [19:0]        range_i,
  input  logic [9:0]         index_i,
  input  logic signed [15:0] pan_i,
  input  logic signed [15:0] tilt_i,
  output logic               valid_o,
  input  logic               ready_i,
  output cell_data_t         data_o
);

  logic [2:0] valid_q;
  logic [2:0] rdy;

  logic signed [29:0] beam0_q, pan0_q, tilt0_q;
  logic [19:0]        range0_q, range1_q;
  logic signed [27:0] beam1_q, pan1_q, tilt1_q;
  cell_data_t         data2_q;

  logic [9:0]         idx_sat;
  logic [27:0]        step_prod;
  logic signed [29:0] first_ext, beam_d, pan_d, tilt_d;

  // advance a stage when it is empty or its successor moves
  assign rdy[2]  = !valid_q[2] || ready_i;
  assign rdy[1]  = !valid_q[1] || rdy[2];
  assign rdy[0]  = !valid_q[0] || rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = valid_q[2];
  assign data_o  = data2_q;

  // beam angle and joint angles in 2^-24 rad
  always_comb begin
    idx_sat   = (32'(index_i) > MAX_SAMPLES - 1) ? IDX_MAX : index_i;
    step_prod = idx_sat * cfg_i.angle_inc;
    first_ext = {{3{cfg_i.first_angle[15]}}, cfg_i.first_angle, 11'd0};
    beam_d    = first_ext + $signed({2'b00, step_prod});
    pan_d     = {{3{pan_i[15]}}, pan_i, 11'd0};
    tilt_d    = {{3{tilt_i[15]}}, tilt_i, 11'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= valid_i;
      if (rdy[1]) valid_q[1] <= valid_q[0];
      if (rdy[2]) valid_q[2] <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      beam0_q  <= beam_d;
      pan0_q   <= pan_d;
      tilt0_q  <= tilt_d;
      range0_q <= range_i;
    end
    if (rdy[1]) begin
      beam1_q  <= wrap_angle(beam0_q);
      pan1_q   <= wrap_angle(pan0_q);
      tilt1_q  <= wrap_angle(tilt0_q);
      range1_q <= range0_q;
    end
    if (rdy[2]) begin
      data2_q.beam  <= fold_lane(beam1_q);
      data2_q.pan   <= fold_lane(pan1_q);
      data2_q.tilt  <= fold_lane(tilt1_q);
      data2_q.range <= range1_q;
    end
  end

endmodule

/* hw/rtl/spt_cell.sv */
// One rotation cell: a single step for the beam, pan and tilt lanes.
// Depends on spt_pkg; chained ROTATION_STEPS times in the top level.
module spt_cell import spt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [4:0]         shift_i,
  input  logic signed [27:0] atan_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  cell_data_t         data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output cell_data_t         data_o
);

  logic       valid_q;
  cell_data_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // rotate all three lanes by one step, pass the range along
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q.beam  <= cordic_step(data_i.beam, shift_i, atan_i);
      data_q.pan   <= cordic_step(data_i.pan, shift_i, atan_i);
      data_q.tilt  <= cordic_step(data_i.tilt, shift_i, atan_i);
      data_q.range <= data_i.range;
    end
  end

endmodule

/* hw/rtl/spt_combine.sv */
// Back end: trig rounding, products, coordinate sums and output saturation.
// Depends on spt_pkg; takes the last spt_cell and drives the result ports.
module spt_combine import spt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  cell_data_t         data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [21:0] point_x_o,
  output logic signed [21:0] point_y_o,
  output logic signed [21:0] point_z_o
);

  localparam int NS = 8;

  logic [NS-1:0] valid_q;
  logic [NS-1:0] rdy;

  // stage 0
  logic [19:0]        r0_q;
  logic signed [17:0] cb0_q, sb0_q, cp0_q, sp0_q, ct0_q, st0_q;
  // stage 1
  logic signed [37:0] xx1_q, yy1_q, ls1_q;
  logic signed [17:0] cp1_q, sp1_q, ct1_q, st1_q;
  // stage 2
  part_t              yyct2_q, xxcp2_q, xxsp2_q, yyst2_q, lssp2_q, lscp2_q;
  logic signed [33:0] l2sp2_q, l2cp2_q, l1ct2_q;
  logic signed [17:0] cp2_q, sp2_q;
  // stage 3
  logic signed [37:0] yt3_q;
  logic signed [55:0] xxcp3_q, xxsp3_q, yyst3_q, lssp3_q, lscp3_q;
  logic signed [33:0] l2sp3_q, l2cp3_q, l1ct3_q;
  logic signed [17:0] cp3_q, sp3_q;
  // stage 4
  part_t              ytsp4_q, ytcp4_q;
  logic signed [55:0] xxcp4_q, xxsp4_q, yyst4_q, lssp4_q, lscp4_q;
  logic signed [33:0] l2sp4_q, l2cp4_q, l1ct4_q;
  // stage 5
  logic signed [55:0] ytsp5_q, ytcp5_q;
  logic signed [55:0] xxcp5_q, xxsp5_q, yyst5_q, lssp5_q, lscp5_q;
  logic signed [33:0] l2sp5_q, l2cp5_q, l1ct5_q;
  // stage 6
  logic signed [57:0] ax6_q, ay6_q, az6_q;
  // stage 7
  logic signed [21:0] px_q, py_q, pz_q;

  logic signed [55:0] yyct_full;
  logic signed [55:0] yt_round;
  logic signed [57:0] t_xxcp, t_ytsp, t_lssp, t_l2sp;
  logic signed [57:0] t_xxsp, t_ytcp, t_lscp, t_l2cp, t_d2;
  logic signed [57:0] t_yyst, t_l1ct, t_d1;

  // advance a stage when it is empty or its successor moves
  always_comb begin
    rdy[NS-1] = !valid_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign ready_o   = rdy[0];
  assign valid_o   = valid_q[NS-1];
  assign point_x_o = px_q;
  assign point_y_o = py_q;
  assign point_z_o = pz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // round the tilt-scaled term and line up all terms at 32 fraction bits
  always_comb begin
    yyct_full = mul_join(yyct2_q);
    yt_round  = (yyct_full + 56'sd32768) >>> 16;
    t_xxcp = xxcp5_q;
    t_ytsp = ytsp5_q;
    t_lssp = lssp5_q;
    t_l2sp = l2sp5_q;
    t_l2sp = t_l2sp <<< 16;
    t_xxsp = xxsp5_q;
    t_ytcp = ytcp5_q;
    t_lscp = lscp5_q;
    t_l2cp = l2cp5_q;
    t_l2cp = t_l2cp <<< 16;
    t_d2   = $signed({42'd0, cfg_i.base_shift}) <<< 32;
    t_yyst = yyst5_q;
    t_l1ct = l1ct5_q;
    t_l1ct = t_l1ct <<< 16;
    t_d1   = $signed({42'd0, cfg_i.base_height}) <<< 32;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      r0_q  <= data_i.range;
      cb0_q <= round_trig(data_i.beam.x, data_i.beam.neg);
      sb0_q <= round_trig(data_i.beam.y, data_i.beam.neg);
      cp0_q <= round_trig(data_i.pan.x, data_i.pan.neg);
      sp0_q <= round_trig(data_i.pan.y, data_i.pan.neg);
      ct0_q <= round_trig(data_i.tilt.x, data_i.tilt.neg);
      st0_q <= round_trig(data_i.tilt.y, data_i.tilt.neg);
    end
    // planar point and tilt arm offset
    if (rdy[1]) begin
      xx1_q <= $signed({1'b0, r0_q}) * cb0_q;
      yy1_q <= $signed({1'b0, r0_q}) * sb0_q;
      ls1_q <= $signed({1'b0, cfg_i.tilt_arm}) * st0_q;
      cp1_q <= cp0_q;
      sp1_q <= sp0_q;
      ct1_q <= ct0_q;
      st1_q <= st0_q;
    end
    // partial products of the wide terms
    if (rdy[2]) begin
      yyct2_q <= mul_split(yy1_q, ct1_q);
      xxcp2_q <= mul_split(xx1_q, cp1_q);
      xxsp2_q <= mul_split(xx1_q, sp1_q);
      yyst2_q <= mul_split(yy1_q, st1_q);
      lssp2_q <= mul_split(ls1_q, sp1_q);
      lscp2_q <= mul_split(ls1_q, cp1_q);
      l2sp2_q <= $signed({1'b0, cfg_i.pan_arm}) * sp1_q;
      l2cp2_q <= $signed({1'b0, cfg_i.pan_arm}) * cp1_q;
      l1ct2_q <= $signed({1'b0, cfg_i.tilt_arm}) * ct1_q;
      cp2_q   <= cp1_q;
      sp2_q   <= sp1_q;
    end
    // join partials, round yy*ct
    if (rdy[3]) begin
      yt3_q   <= yt_round[37:0];
      xxcp3_q <= mul_join(xxcp2_q);
      xxsp3_q <= mul_join(xxsp2_q);
      yyst3_q <= mul_join(yyst2_q);
      lssp3_q <= mul_join(lssp2_q);
      lscp3_q <= mul_join(lscp2_q);
      l2sp3_q <= l2sp2_q;
      l2cp3_q <= l2cp2_q;
      l1ct3_q <= l1ct2_q;
      cp3_q   <= cp2_q;
      sp3_q   <= sp2_q;
    end
    if (rdy[4]) begin
      ytsp4_q <= mul_split(yt3_q, sp3_q);
      ytcp4_q <= mul_split(yt3_q, cp3_q);
      xxcp4_q <= xxcp3_q;
      xxsp4_q <= xxsp3_q;
      yyst4_q <= yyst3_q;
      lssp4_q <= lssp3_q;
      lscp4_q <= lscp3_q;
      l2sp4_q <= l2sp3_q;
      l2cp4_q <= l2cp3_q;
      l1ct4_q <= l1ct3_q;
    end
    if (rdy[5]) begin
      ytsp5_q <= mul_join(ytsp4_q);
      ytcp5_q <= mul_join(ytcp4_q);
      xxcp5_q <= xxcp4_q;
      xxsp5_q <= xxsp4_q;
      yyst5_q <= yyst4_q;
      lssp5_q <= lssp4_q;
      lscp5_q <= lscp4_q;
      l2sp5_q <= l2sp4_q;
      l2cp5_q <= l2cp4_q;
      l1ct5_q <= l1ct4_q;
    end
    // coordinate sums
    if (rdy[6]) begin
      ax6_q <= t_xxcp - t_ytsp + t_lssp + t_l2sp;
      ay6_q <= t_xxsp + t_ytcp - t_lscp + t_l2cp - t_d2;
      az6_q <= t_yyst + t_l1ct + t_d1;
    end
    if (rdy[7]) begin
      px_q <= sat_out(ax6_q);
      py_q <= sat_out(ay6_q);
      pz_q <= sat_out(az6_q);
    end
  end

endmodule

/* hw/rtl/scan_point_pan_tilt_transform.sv */
// Top level of the scan point pan/tilt transform: configuration registers,
// angle front end, rotation cell chain and coordinate back end. Uses spt_pkg.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------------
//   in       | sink      | in_valid_i / in_stall_o | range, index, pan, tilt
//   out      | source    | out_valid_o/out_stall_i | point_x, point_y, point_z
//   cfg      | sink      | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One transaction per clock cycle unless out_stall_i holds a result; the
// rotation cell chain does one step per cell.
// Every stage moves when it is empty or its successor moves, so empty stages
// keep taking input while a result waits on out_stall_i.
// Reset clears all valid flags and loads the register defaults.
module scan_point_pan_tilt_transform import spt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [19:0]           range_value_i,
  input  logic [9:0]            sample_index_i,
  input  logic signed [15:0]    pan_angle_i,
  input  logic signed [15:0]    tilt_angle_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [21:0]    point_x_o,
  output logic signed [21:0]    point_y_o,
  output logic signed [21:0]    point_z_o
);

  cfg_t cfg_q;

  logic       front_ready;
  logic       cell_valid [0:ROTATION_STEPS];
  logic       cell_ready [0:ROTATION_STEPS];
  cell_data_t cell_data  [0:ROTATION_STEPS];

  // register writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ANGLE_INC:   cfg_q.angle_inc   <= cfg_data_i;
        REG_FIRST_ANGLE: cfg_q.first_angle <= cfg_data_i[15:0];
        REG_TILT_ARM:    cfg_q.tilt_arm    <= cfg_data_i[15:0];
        REG_PAN_ARM:     cfg_q.pan_arm     <= cfg_data_i[15:0];
        REG_BASE_HEIGHT: cfg_q.base_height <= cfg_data_i[15:0];
        REG_BASE_SHIFT:  cfg_q.base_shift  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !front_ready;

  spt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .range_i (range_value_i),
    .index_i (sample_index_i),
    .pan_i   (pan_angle_i),
    .tilt_i  (tilt_angle_i),
    .valid_o (cell_valid[0]),
    .ready_i (cell_ready[0]),
    .data_o  (cell_data[0])
  );

  // rotation chain, one step per cell
  for (genvar k = 0; k < ROTATION_STEPS; k++) begin : g_cell
    spt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (5'(k)),
      .atan_i  (atan_of(5'(k))),
      .valid_i (cell_valid[k]),
      .ready_o (cell_ready[k]),
      .data_i  (cell_data[k]),
      .valid_o (cell_valid[k+1]),
      .ready_i (cell_ready[k+1]),
      .data_o  (cell_data[k+1])
    );
  end

  spt_combine u_combine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (cell_valid[ROTATION_STEPS]),
    .ready_o   (cell_ready[ROTATION_STEPS]),
    .data_i    (cell_data[ROTATION_STEPS]),
    .valid_o   (out_valid_o),
    .ready_i   (!out_stall_i),
    .point_x_o (point_x_o),
    .point_y_o (point_y_o),
    .point_z_o (point_z_o)
  );

  // an empty output stage frees the whole pipeline
  a_no_stall_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o) else $error("input stalled with output empty");

  // input stall only comes from a held result
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("stall without backpressure");

  // the beam step register changes only through its write
  a_inc_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_we_i && cfg_index_i == REG_ANGLE_INC) |=> $stable(cfg_q.angle_inc))
    else $error("angle increment changed without a write");

endmodule
